FILE: sv/mcp_pkg.sv
// Shared types and constants for the matrix column permutation block.
package mcp_pkg;

	localparam int PERM_W = 5;
	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		OP_WR_PERM = 2'd0,
		OP_WR_ELEM = 2'd1,
		OP_APPLY   = 2'd2,
		OP_RD_ELEM = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

	localparam logic DIRECTION_RESET = 1'b1;
	localparam logic [CFG_W-1:0] ROWS_RESET = 5'd16;
	localparam logic [CFG_W-1:0] COLS_RESET = 5'd16;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_PERM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic accept;
		logic v_issue;
		logic v_check;
		logic v_clear;
		logic o_issue;
		logic o_next;
		logic load_nxt;
		logic row_clr;
		logic sw_ra;
		logic sw_rb;
		logic sw_wb;
		logic sw_wa;
		logic mark_adv;
		logic finish;
		logic fin_bad;
	} cmd_t;

	typedef struct packed {
		logic ncols_small;
		logic vis_idx;
		logic idx_last;
		logic chk_bad;
		logic cyc_more;
		logic row_last;
		logic rows_zero;
	} sts_t;

endpackage

FILE: sv/matrix_column_permute_top.sv
// Top level of the matrix column permutation block.
// A transaction is taken at a clock edge with start high and busy low; operation selects
// a table entry write, an element write, an apply or an element read.
// Every transaction gives one result: done is high for exactly one cycle with read_value
// and status; the receiver cannot stall, so the result must be taken in that cycle.
// Table writes, element writes and reads are not blocking: busy stays low, a new
// transaction can be taken every cycle and its result appears in the next cycle.
// Apply raises busy while it runs. It first checks the table one column at a time,
// then walks the permutation cycles: a wait and a test state per column visited and
// two reads and two writes per row for every column swap, the single matrix memory
// port pair being the limit. Its result appears in the first cycle with busy low again.
// With one column or fewer in use, apply leaves busy low and answers in the next cycle
// like the others. A table that is not a permutation ends the check early with status 1
// and the matrix untouched.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and are meant
// for idle periods only. Reset restores direction forward and 16 rows and columns and
// clears the visited marks; matrix and table contents are undefined until written.
module matrix_column_permute_top #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	parameter int ELEM_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [3:0]                      row,
	input  logic [3:0]                      col,
	input  logic [mcp_pkg::PERM_W-1:0]      perm_value,
	input  logic [ELEM_WIDTH-1:0]           element,
	output logic                            done,
	output logic [ELEM_WIDTH-1:0]           read_value,
	output logic [mcp_pkg::STATUS_W-1:0]    status,
	input  logic                            cfg_we,
	input  logic [mcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcp_pkg::CFG_W-1:0]       cfg_data
);

	mcp_pkg::cmd_t cmd;
	mcp_pkg::sts_t sts;

	mcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	mcp_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.row        (row),
		.col        (col),
		.perm_value (perm_value),
		.element    (element),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.read_value (read_value),
		.status     (status)
	);

	// A non-apply transaction is answered in the very next cycle.
	a_simple_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation != mcp_pkg::OP_APPLY) |=> done)
		else $error("element or table transaction not answered in the next cycle");

	// An accepted apply either finishes at once or keeps the block busy.
	a_apply_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == mcp_pkg::OP_APPLY) |=> (busy || done))
		else $error("apply neither answered nor in progress");

	// Results are only ever given while the sequencer is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while apply still running");

	// Outside a result cycle the payload stays at its neutral value.
	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (read_value == '0 && status == mcp_pkg::ST_OK))
		else $error("result payload active without done");

endmodule

FILE: sv/mcp_datapath.sv
// Datapath: configuration, matrix and table memories, walk counters and result registers.
module mcp_datapath #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	parameter int ELEM_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mcp_pkg::cmd_t                   cmd,
	output mcp_pkg::sts_t                   sts,
	input  logic [1:0]                      operation,
	input  logic [3:0]                      row,
	input  logic [3:0]                      col,
	input  logic [mcp_pkg::PERM_W-1:0]      perm_value,
	input  logic [ELEM_WIDTH-1:0]           element,
	input  logic                            cfg_we,
	input  logic [mcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcp_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic [ELEM_WIDTH-1:0]           read_value,
	output logic [mcp_pkg::STATUS_W-1:0]    status
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int VIS_N = 2 ** COL_W;
	localparam int SZ_A = $clog2(MAX_ROWS + 1);
	localparam int SZ_B = $clog2(MAX_COLS + 1);
	localparam int SZ_AB = (SZ_A > SZ_B) ? SZ_A : SZ_B;
	localparam int SZ_W = (SZ_AB > mcp_pkg::PERM_W) ? SZ_AB : mcp_pkg::PERM_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r);
		addr_of = ADDR_W'(c) * ADDR_W'(MAX_ROWS) + ADDR_W'(r);
	endfunction

	logic                            dir_q;
	logic [mcp_pkg::CFG_W-1:0]       rows_q;
	logic [mcp_pkg::CFG_W-1:0]       cols_q;
	logic [SZ_W-1:0]                 rows_x;
	logic [SZ_W-1:0]                 cols_x;
	logic [SZ_W-1:0]                 nrows;
	logic [SZ_W-1:0]                 ncols;
	logic [SZ_W-1:0]                 row_x;
	logic [SZ_W-1:0]                 col_x;
	logic                            row_ok;
	logic                            col_ok;
	logic                            addr_ok;
	logic [ROW_W-1:0]                row_i;
	logic [COL_W-1:0]                col_i;
	mcp_pkg::op_t                    op;
	logic                            simple_op;

	logic [ELEM_WIDTH-1:0]           mat_mem [DEPTH];
	logic [ELEM_WIDTH-1:0]           mrd_q;
	logic [ELEM_WIDTH-1:0]           tmp_q;
	logic [mcp_pkg::PERM_W-1:0]      perm_mem [MAX_COLS];
	logic [mcp_pkg::PERM_W-1:0]      prd_q;

	logic                            m_we;
	logic [ADDR_W-1:0]               m_wa;
	logic [ELEM_WIDTH-1:0]           m_wd;
	logic                            m_re;
	logic [ADDR_W-1:0]               m_ra;
	logic                            p_we;
	logic                            p_re;
	logic [COL_W-1:0]                p_ra;

	logic [COL_W-1:0]                idx_q;
	logic [COL_W-1:0]                base_q;
	logic [COL_W-1:0]                cur_q;
	logic [COL_W-1:0]                nxt_q;
	logic [COL_W-1:0]                col_a;
	logic [ROW_W-1:0]                row_q;
	logic [VIS_N-1:0]                visited_q;
	logic [SZ_W-1:0]                 p_x;
	logic [SZ_W-1:0]                 pm1;
	logic [COL_W-1:0]                p_idx;

	logic                            done_q;
	logic                            rsel_q;
	logic [mcp_pkg::STATUS_W-1:0]    status_q;

	assign rows_x = SZ_W'(rows_q);
	assign cols_x = SZ_W'(cols_q);
	assign nrows = (rows_x > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS) : rows_x;
	assign ncols = (cols_x > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS) : cols_x;
	assign row_x = SZ_W'(row);
	assign col_x = SZ_W'(col);
	assign row_ok = row_x < nrows;
	assign col_ok = col_x < ncols;
	assign row_i = row_x[ROW_W-1:0];
	assign col_i = col_x[COL_W-1:0];
	assign op = mcp_pkg::op_t'(operation);
	assign simple_op = cmd.accept && (op != mcp_pkg::OP_APPLY);
	assign addr_ok = (op == mcp_pkg::OP_WR_PERM) ? col_ok : (row_ok && col_ok);

	// Table entries hold one-based column numbers.
	assign p_x = SZ_W'(prd_q);
	assign pm1 = p_x - SZ_W'(1);
	assign p_idx = pm1[COL_W-1:0];

	// Forward swaps along the chain; backward always swaps with the cycle's first column.
	assign col_a = dir_q ? cur_q : base_q;

	assign sts.ncols_small = ncols <= SZ_W'(1);
	assign sts.vis_idx = visited_q[idx_q];
	assign sts.idx_last = SZ_W'(idx_q) == (ncols - SZ_W'(1));
	assign sts.chk_bad = (p_x == '0) || (p_x > ncols) || visited_q[p_idx];
	assign sts.cyc_more = dir_q ? !visited_q[nxt_q] : (nxt_q != base_q);
	assign sts.row_last = SZ_W'(row_q) == (nrows - SZ_W'(1));
	assign sts.rows_zero = nrows == '0;

	always_comb begin
		m_we = 1'b0;
		m_wa = addr_of(col_i, row_i);
		m_wd = element;
		priority if (simple_op && op == mcp_pkg::OP_WR_ELEM && row_ok && col_ok) begin
			m_we = 1'b1;
		end else if (cmd.sw_wb) begin
			m_we = 1'b1;
			m_wa = addr_of(nxt_q, row_q);
			m_wd = tmp_q;
		end else if (cmd.sw_wa) begin
			m_we = 1'b1;
			m_wa = addr_of(col_a, row_q);
			m_wd = mrd_q;
		end else begin
			m_we = 1'b0;
		end
	end

	always_comb begin
		m_re = 1'b0;
		m_ra = addr_of(col_i, row_i);
		priority if (simple_op && op == mcp_pkg::OP_RD_ELEM && row_ok && col_ok) begin
			m_re = 1'b1;
		end else if (cmd.sw_ra) begin
			m_re = 1'b1;
			m_ra = addr_of(col_a, row_q);
		end else if (cmd.sw_rb) begin
			m_re = 1'b1;
			m_ra = addr_of(nxt_q, row_q);
		end else begin
			m_re = 1'b0;
		end
	end

	assign p_we = simple_op && (op == mcp_pkg::OP_WR_PERM) && col_ok;
	assign p_re = cmd.v_issue || cmd.o_issue || cmd.mark_adv;
	assign p_ra = cmd.mark_adv ? nxt_q : idx_q;

	always_ff @(posedge clk) begin
		if (m_we) begin
			mat_mem[m_wa] <= m_wd;
		end
		if (m_re) begin
			mrd_q <= mat_mem[m_ra];
		end
		if (cmd.sw_rb) begin
			tmp_q <= mrd_q;
		end
		if (p_we) begin
			perm_mem[col_i] <= perm_value;
		end
		if (p_re) begin
			prd_q <= perm_mem[p_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= mcp_pkg::DIRECTION_RESET;
			rows_q <= mcp_pkg::ROWS_RESET;
			cols_q <= mcp_pkg::COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcp_pkg::CFG_DIRECTION: dir_q <= cfg_data[0];
				mcp_pkg::CFG_ROWS:      rows_q <= cfg_data;
				mcp_pkg::CFG_COLS:      cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			base_q <= '0;
			cur_q <= '0;
			nxt_q <= '0;
			row_q <= '0;
			visited_q <= '0;
		end else begin
			if (cmd.accept || cmd.v_clear) begin
				idx_q <= '0;
			end else if (cmd.v_check || cmd.o_next) begin
				idx_q <= idx_q + COL_W'(1);
			end
			if (cmd.o_issue) begin
				base_q <= idx_q;
				cur_q <= idx_q;
			end else if (cmd.mark_adv) begin
				cur_q <= nxt_q;
			end
			if (cmd.load_nxt) begin
				nxt_q <= p_idx;
			end
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.sw_wa) begin
				row_q <= row_q + ROW_W'(1);
			end
			priority if (cmd.accept || cmd.v_clear || cmd.finish) begin
				visited_q <= '0;
			end else if (cmd.v_check) begin
				visited_q[p_idx] <= 1'b1;
			end else if (cmd.o_issue) begin
				visited_q[idx_q] <= 1'b1;
			end else if (cmd.mark_adv) begin
				visited_q[nxt_q] <= 1'b1;
			end else begin
				visited_q <= visited_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rsel_q <= 1'b0;
			status_q <= mcp_pkg::ST_OK;
		end else begin
			done_q <= simple_op || cmd.finish;
			rsel_q <= simple_op && (op == mcp_pkg::OP_RD_ELEM) && row_ok && col_ok;
			priority if (cmd.finish) begin
				status_q <= cmd.fin_bad ? mcp_pkg::ST_BAD_PERM : mcp_pkg::ST_OK;
			end else if (simple_op && !addr_ok) begin
				status_q <= mcp_pkg::ST_RANGE;
			end else begin
				status_q <= mcp_pkg::ST_OK;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign read_value = rsel_q ? mrd_q : '0;

endmodule

FILE: sv/mcp_ctrl.sv
// Controller: sequences table checking, cycle following and column swaps.
module mcp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    operation,
	input  mcp_pkg::sts_t sts,
	output mcp_pkg::cmd_t cmd,
	output logic          busy
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_V_RD  = 10'b0000000010,
		ST_V_CHK = 10'b0000000100,
		ST_O_TST = 10'b0000001000,
		ST_O_WT  = 10'b0000010000,
		ST_C_TST = 10'b0000100000,
		ST_SW_RA = 10'b0001000000,
		ST_SW_RB = 10'b0010000000,
		ST_SW_WB = 10'b0100000000,
		ST_SW_WA = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (mcp_pkg::op_t'(operation) == mcp_pkg::OP_APPLY) begin
						if (sts.ncols_small) begin
							cmd.finish = 1'b1;
						end else begin
							state_d = ST_V_RD;
						end
					end
				end
			end
			ST_V_RD: begin
				cmd.v_issue = 1'b1;
				state_d = ST_V_CHK;
			end
			ST_V_CHK: begin
				if (sts.chk_bad) begin
					cmd.finish = 1'b1;
					cmd.fin_bad = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.idx_last) begin
					cmd.v_clear = 1'b1;
					state_d = ST_O_TST;
				end else begin
					cmd.v_check = 1'b1;
					state_d = ST_V_RD;
				end
			end
			ST_O_TST: begin
				if (!sts.vis_idx) begin
					cmd.o_issue = 1'b1;
					state_d = ST_O_WT;
				end else if (sts.idx_last) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.o_next = 1'b1;
				end
			end
			ST_O_WT: begin
				cmd.load_nxt = 1'b1;
				state_d = ST_C_TST;
			end
			ST_C_TST: begin
				if (sts.cyc_more) begin
					if (sts.rows_zero) begin
						cmd.mark_adv = 1'b1;
						state_d = ST_O_WT;
					end else begin
						cmd.row_clr = 1'b1;
						state_d = ST_SW_RA;
					end
				end else if (sts.idx_last) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.o_next = 1'b1;
					state_d = ST_O_TST;
				end
			end
			ST_SW_RA: begin
				cmd.sw_ra = 1'b1;
				state_d = ST_SW_RB;
			end
			ST_SW_RB: begin
				cmd.sw_rb = 1'b1;
				state_d = ST_SW_WB;
			end
			ST_SW_WB: begin
				cmd.sw_wb = 1'b1;
				state_d = ST_SW_WA;
			end
			ST_SW_WA: begin
				cmd.sw_wa = 1'b1;
				if (sts.row_last) begin
					cmd.mark_adv = 1'b1;
					state_d = ST_O_WT;
				end else begin
					state_d = ST_SW_RA;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

FILE: test/matrix_column_permute_checker.sv
// Checker for the matrix column permutation block: predicts every result and compares it.
module matrix_column_permute_checker #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16,
	parameter int ELEM_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      operation,
	input  logic [3:0]                      row,
	input  logic [3:0]                      col,
	input  logic [mcp_pkg::PERM_W-1:0]      perm_value,
	input  logic [ELEM_WIDTH-1:0]           element,
	input  logic                            done,
	input  logic [ELEM_WIDTH-1:0]           read_value,
	input  logic [mcp_pkg::STATUS_W-1:0]    status,
	input  logic                            cfg_we,
	input  logic [mcp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcp_pkg::CFG_W-1:0]       cfg_data,
	output int                              misses,
	output int                              outstanding
);

	typedef struct packed {
		logic [ELEM_WIDTH-1:0]        value;
		logic [mcp_pkg::STATUS_W-1:0] status;
	} answer_t;

	answer_t answers_due[$];

	logic [ELEM_WIDTH-1:0]      cells [MAX_COLS][MAX_ROWS];
	logic [mcp_pkg::PERM_W-1:0] src_col [MAX_COLS];
	logic                       fwd = mcp_pkg::DIRECTION_RESET;
	logic [mcp_pkg::CFG_W-1:0]  rows_cfg = mcp_pkg::ROWS_RESET;
	logic [mcp_pkg::CFG_W-1:0]  cols_cfg = mcp_pkg::COLS_RESET;
	int                         miss_count = 0;

	// Works out the answer of one transaction and updates the predicted matrix and table.
	task automatic work_out(input mcp_pkg::op_t op, input logic [3:0] r,
			input logic [3:0] c, input logic [mcp_pkg::PERM_W-1:0] pv,
			input logic [ELEM_WIDTH-1:0] e, output answer_t ans);
		int nr;
		int nc;
		int p;
		logic bad;
		logic [MAX_COLS-1:0] seen;
		logic [ELEM_WIDTH-1:0] snap [MAX_COLS][MAX_ROWS];
		nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
		nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
		ans.value = '0;
		ans.status = mcp_pkg::ST_OK;
		case (op)
			mcp_pkg::OP_WR_PERM: begin
				if (c < nc)
					src_col[c] = pv;
				else
					ans.status = mcp_pkg::ST_RANGE;
			end
			mcp_pkg::OP_WR_ELEM: begin
				if (r < nr && c < nc)
					cells[c][r] = e;
				else
					ans.status = mcp_pkg::ST_RANGE;
			end
			mcp_pkg::OP_APPLY: begin
				if (nc > 1) begin
					seen = '0;
					bad = 1'b0;
					for (int i = 0; i < nc; i++) begin
						p = src_col[i];
						if (p < 1 || p > nc || seen[p-1])
							bad = 1'b1;
						else
							seen[p-1] = 1'b1;
					end
					if (bad) begin
						ans.status = mcp_pkg::ST_BAD_PERM;
					end else begin
						// Forward gathers new column j from old column perm(j);
						// backward scatters old column j into column perm(j).
						snap = cells;
						for (int j = 0; j < nc; j++) begin
							for (int rr = 0; rr < nr; rr++) begin
								if (fwd)
									cells[j][rr] = snap[src_col[j]-1][rr];
								else
									cells[src_col[j]-1][rr] = snap[j][rr];
							end
						end
					end
				end
			end
			default: begin
				if (r < nr && c < nc)
					ans.value = cells[c][r];
				else
					ans.status = mcp_pkg::ST_RANGE;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			fwd = mcp_pkg::DIRECTION_RESET;
			rows_cfg = mcp_pkg::ROWS_RESET;
			cols_cfg = mcp_pkg::COLS_RESET;
			answers_due.delete();
			miss_count = 0;
		end else begin
			// The oldest transaction's result is retired before a new one is queued.
			if (done === 1'b1) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with none expected: read_value %h status %0d",
						$time, read_value, status);
					miss_count++;
				end else begin
					want = answers_due.pop_front();
					if (read_value !== want.value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, want.value, read_value);
						miss_count++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						miss_count++;
					end
				end
			end
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					mcp_pkg::CFG_DIRECTION: fwd = cfg_data[0];
					mcp_pkg::CFG_ROWS:      rows_cfg = cfg_data;
					mcp_pkg::CFG_COLS:      cols_cfg = cfg_data;
					default:                ;
				endcase
			end
			if (start === 1'b1 && busy === 1'b0) begin
				work_out(mcp_pkg::op_t'(operation), row, col, perm_value, element, want);
				answers_due.push_back(want);
			end
		end
		misses <= miss_count;
		outstanding <= answers_due.size();
	end

endmodule

FILE: test/matrix_column_permute_top_tb.sv
// Testbench top for the matrix column permutation block: stimulus, configuration and verdict.
module matrix_column_permute_top_tb;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ELEM_W = 64;
	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT = 4000000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [1:0]                    operation = mcp_pkg::OP_WR_PERM;
	logic [3:0]                    row = '0;
	logic [3:0]                    col = '0;
	logic [mcp_pkg::PERM_W-1:0]    perm_value = '0;
	logic [ELEM_W-1:0]             element = '0;
	logic                          cfg_we = 1'b0;
	logic [mcp_pkg::CFG_IDX_W-1:0] cfg_index = mcp_pkg::CFG_DIRECTION;
	logic [mcp_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          busy;
	logic                          done;
	logic [ELEM_W-1:0]             read_value;
	logic [mcp_pkg::STATUS_W-1:0]  status;
	int                            misses;
	int                            outstanding;

	int cycle_count = 0;
	int sent = 0;
	int eff_rows = MAX_ROWS;
	int eff_cols = MAX_COLS;
	int perm_now [MAX_COLS];
	bit calm = 1'b0;

	matrix_column_permute_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ELEM_WIDTH(ELEM_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.row(row),
		.col(col),
		.perm_value(perm_value),
		.element(element),
		.done(done),
		.read_value(read_value),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	matrix_column_permute_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ELEM_WIDTH(ELEM_W)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.row(row),
		.col(col),
		.perm_value(perm_value),
		.element(element),
		.done(done),
		.read_value(read_value),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.misses(misses),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("matrix_column_permute_top_tb: errors");
			$finish;
		end
	end

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly inside the sizes in use, now and then anywhere in the field.
	function automatic logic [3:0] pick_index(input int lim);
		if (lim > 0 && $urandom_range(0, 99) < 85)
			return 4'($urandom_range(0, lim - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// Presents one transaction and returns in the time step of the edge that takes it.
	task automatic send_item(input mcp_pkg::op_t op, input logic [3:0] r,
			input logic [3:0] c, input logic [mcp_pkg::PERM_W-1:0] pv,
			input logic [ELEM_W-1:0] e);
		if (!calm) begin
			while ($urandom_range(0, 99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		operation <= op;
		row <= r;
		col <= c;
		perm_value <= pv;
		element <= e;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
	endtask

	// Waits until every result is in and the block has gone quiet.
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy !== 1'b0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic dir, input logic [mcp_pkg::CFG_W-1:0] nrows,
			input logic [mcp_pkg::CFG_W-1:0] ncols);
		logic [mcp_pkg::CFG_W-1:0] dir_word;
		settle();
		dir_word = {4'($urandom_range(0, 15)), dir};
		cfg_we <= 1'b1;
		cfg_index <= mcp_pkg::CFG_DIRECTION;
		cfg_data <= dir_word;
		@(posedge clk);
		cfg_index <= mcp_pkg::CFG_ROWS;
		cfg_data <= nrows;
		@(posedge clk);
		cfg_index <= mcp_pkg::CFG_COLS;
		cfg_data <= ncols;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_rows = (nrows > MAX_ROWS) ? MAX_ROWS : nrows;
		eff_cols = (ncols > MAX_COLS) ? MAX_COLS : ncols;
	endtask

	// Loads a fresh random permutation of 1..n into the first n table entries.
	task automatic load_perm(input int n);
		int order [MAX_COLS];
		int k;
		int t;
		for (int i = 0; i < n; i++)
			order[i] = i + 1;
		for (int i = n - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			t = order[i];
			order[i] = order[k];
			order[k] = t;
		end
		for (int i = 0; i < n; i++) begin
			send_item(mcp_pkg::OP_WR_PERM, 4'($urandom), 4'(i), 5'(order[i]), rand_elem());
			perm_now[i] = order[i];
		end
	endtask

	function automatic logic [mcp_pkg::CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return 5'd0;
			1:       return 5'd1;
			2:       return 5'd16;
			3:       return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(2, 15));
		endcase
	endfunction

	initial begin
		int base;
		int pick;
		int a;
		int b;
		int pa;
		logic [3:0] c;
		logic [mcp_pkg::PERM_W-1:0] pv;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole matrix and table at the reset sizes, so that no later read or
		// apply ever touches an entry that was never written.
		for (int cc = 0; cc < MAX_COLS; cc++)
			for (int rr = 0; rr < MAX_ROWS; rr++)
				send_item(mcp_pkg::OP_WR_ELEM, 4'(rr), 4'(cc), 5'($urandom), rand_elem());
		load_perm(MAX_COLS);

		// Directed part: field extremes, both directions, bad tables and odd sizes.
		send_item(mcp_pkg::OP_WR_ELEM, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_WR_ELEM, 4'd15, 4'd15, 5'd31, '1);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd15, 4'd15, 5'd31, '1);
		send_item(mcp_pkg::OP_WR_ELEM, 4'd15, 4'd0, 5'd16, {32{2'b10}});
		send_item(mcp_pkg::OP_RD_ELEM, 4'd15, 4'd0, 5'd1, '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd15, 5'd0, '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd15, 5'd31, '0);
		send_item(mcp_pkg::OP_APPLY, 4'd15, 4'd15, 5'd31, '1);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd15, 5'(perm_now[14]), '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd15, 5'(perm_now[15]), '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		// Sizes above the maxima are taken as the maxima.
		write_config(1'b0, 5'd20, 5'd31);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd15, 4'd15, 5'd0, '0);
		write_config(1'b1, 5'd0, 5'd1);
		send_item(mcp_pkg::OP_WR_ELEM, 4'd0, 4'd0, 5'd0, '1);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd1, 5'd1, '0);
		write_config(1'b0, 5'd8, 5'd0);
		send_item(mcp_pkg::OP_WR_PERM, 4'd0, 4'd0, 5'd1, '0);
		send_item(mcp_pkg::OP_APPLY, 4'd0, 4'd0, 5'd0, '0);
		send_item(mcp_pkg::OP_RD_ELEM, 4'd7, 4'd0, 5'd0, '0);

		// Random part: each phase picks sizes and a direction, loads a proper table and
		// then mixes element traffic, applies and a little table noise.
		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			write_config(1'($urandom), pick_size(), pick_size());
			load_perm(eff_cols);
			repeat ($urandom_range(40, 100)) begin
				calm = (sent - base >= 200 && sent - base < 450);
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					send_item(mcp_pkg::OP_APPLY, 4'($urandom), 4'($urandom), 5'($urandom),
						rand_elem());
				end else if (pick < 55) begin
					send_item(mcp_pkg::OP_WR_ELEM, pick_index(eff_rows), pick_index(eff_cols),
						5'($urandom), rand_elem());
				end else if (pick < 90) begin
					send_item(mcp_pkg::OP_RD_ELEM, pick_index(eff_rows), pick_index(eff_cols),
						5'($urandom), rand_elem());
				end else if (pick < 95 && eff_cols >= 2) begin
					// Exchanging two entries keeps the table a permutation.
					a = $urandom_range(0, eff_cols - 1);
					b = $urandom_range(0, eff_cols - 1);
					pa = perm_now[a];
					send_item(mcp_pkg::OP_WR_PERM, 4'($urandom), 4'(a), 5'(perm_now[b]),
						rand_elem());
					send_item(mcp_pkg::OP_WR_PERM, 4'($urandom), 4'(b), 5'(pa), rand_elem());
					perm_now[a] = perm_now[b];
					perm_now[b] = pa;
				end else begin
					c = 4'($urandom);
					pv = 5'($urandom);
					send_item(mcp_pkg::OP_WR_PERM, 4'($urandom), c, pv, rand_elem());
					if (c < eff_cols)
						perm_now[c] = pv;
				end
			end
		end
		calm = 1'b0;

		settle();
		repeat (16) @(posedge clk);
		if (misses == 0)
			$display("matrix_column_permute_top_tb: clean");
		else
			$display("matrix_column_permute_top_tb: errors");
		$finish;
	end

endmodule
